// ===== hdl/ray_sphere_collision_point_assert.svh =====
// Assertion macros used by the collision pipeline top level
`ifndef RAY_SPHERE_COLLISION_POINT_ASSERT_SVH
`define RAY_SPHERE_COLLISION_POINT_ASSERT_SVH
// Same-cycle implication, ignored while reset is held
`define RSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, also checked across reset
`define RSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/rsc_pkg.sv =====
// Widths, payload types and stage structs for the collision pipeline
`timescale 1ns / 1ps
package rsc_pkg;

  // Coordinate format
  localparam int COORD_W  = 32;
  localparam int FRAC_W   = 16;
  // Derived datapath widths
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int RR_W     = 2 * COORD_W;
  localparam int MAG_W    = PROD_W + 2;
  localparam int HALF_W   = MAG_W / 2;
  localparam int SQR_W    = 2 * MAG_W;
  localparam int D_W      = SQR_W + 2;
  localparam int ROOT_W   = D_W / 2;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int N_W      = ROOT_W + 1;
  localparam int NCH      = 3;
  localparam int NCH_W    = (N_W + NCH - 1) / NCH;
  localparam int PP_W     = NCH_W + DIFF_W;
  localparam int DIV_W    = N_W + DIFF_W;
  localparam int Q_W      = COORD_W + 2;
  localparam int V_W      = Q_W + 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t                   cur_x;
    coord_t                   cur_y;
    coord_t                   cur_z;
    coord_t                   prev_x;
    coord_t                   prev_y;
    coord_t                   prev_z;
    logic [COORD_W-2:0]       mover_radius;
    coord_t                   obstacle_x;
    coord_t                   obstacle_y;
    coord_t                   obstacle_z;
    logic [COORD_W-2:0]       obstacle_radius;
  } in_t;

  typedef struct packed {
    logic                     hit;
    coord_t                   hit_x;
    coord_t                   hit_y;
    coord_t                   hit_z;
    logic [COORD_W-1:0]       hit_time;
  } out_t;

  // Per-axis data carried to the back end (index 0 is x)
  typedef struct packed {
    logic [2:0][COORD_W-1:0]  prv;
    logic [2:0][DIFF_W-1:0]   ud;
    logic [2:0]               dneg;
  } geom_t;

  // Front end to square root
  typedef struct packed {
    logic                     hit;
    logic                     first;
    logic                     hneg;
    logic [MAG_W-1:0]         habs;
    logic [MAG_W-1:0]         a;
    logic [D_W-1:0]           d;
    geom_t                    g;
  } front_t;

  // Square root to back end
  typedef struct packed {
    logic                     hit;
    logic                     first;
    logic                     hneg;
    logic [MAG_W-1:0]         habs;
    logic [MAG_W-1:0]         a;
    logic [ROOT_W-1:0]        root;
    geom_t                    g;
  } root_t;

  // Side data that rides alongside the dividers
  typedef struct packed {
    logic                     hit;
    logic [2:0][COORD_W-1:0]  prv;
    logic [2:0]               dneg;
  } post_t;

endpackage

// ===== hdl/rsc_front.sv =====
// Front end: differences, dot products, discriminant and root choice (7 stages)
`timescale 1ns / 1ps
module rsc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  rsc_pkg::in_t    in_data,
  output logic            fo_valid,
  output rsc_pkg::front_t fo
);

  logic [6:0] vld_r;

  // Stage 1 registers
  logic signed [rsc_pkg::DIFF_W-1:0]   dx1_r [3];
  logic signed [rsc_pkg::DIFF_W-1:0]   e1_r  [3];
  logic [2:0][rsc_pkg::COORD_W-1:0]    prv1_r;
  logic [rsc_pkg::COORD_W-1:0]         rsum1_r;
  // Stage 2 registers
  logic signed [rsc_pkg::PROD_W-1:0]   dd2_r [3];
  logic signed [rsc_pkg::PROD_W-1:0]   de2_r [3];
  logic signed [rsc_pkg::PROD_W-1:0]   ee2_r [3];
  logic [rsc_pkg::RR_W-1:0]            rr2_r;
  rsc_pkg::geom_t                      g2_r;
  // Stage 3 registers
  logic signed [rsc_pkg::MAG_W-1:0]    a3_r, h3_r, ep3_r;
  logic [rsc_pkg::RR_W-1:0]            rr3_r;
  rsc_pkg::geom_t                      g3_r;
  // Stage 4 registers
  logic [rsc_pkg::MAG_W-1:0]           a4_r, habs4_r, cabs4_r;
  logic                                hneg4_r, cpos4_r, cneg4_r, azero4_r;
  rsc_pkg::geom_t                      g4_r;
  // Stage 5 registers
  logic [2*rsc_pkg::HALF_W-1:0]        hh5_r, hl5_r, ll5_r;
  logic [2*rsc_pkg::HALF_W-1:0]        p005_r, p015_r, p105_r, p115_r;
  logic [rsc_pkg::MAG_W-1:0]           a5_r, habs5_r;
  logic                                hneg5_r, cpos5_r, cneg5_r, azero5_r;
  rsc_pkg::geom_t                      g5_r;
  // Stage 6 registers
  logic [rsc_pkg::SQR_W-1:0]           h26_r, ac6_r;
  logic [rsc_pkg::MAG_W-1:0]           a6_r, habs6_r;
  logic                                hneg6_r, cpos6_r, cneg6_r, azero6_r;
  rsc_pkg::geom_t                      g6_r;
  // Stage 7 register
  rsc_pkg::front_t                     fo_r;

  rsc_pkg::coord_t cur [3];
  rsc_pkg::coord_t prv [3];
  rsc_pkg::coord_t obs [3];

  logic signed [rsc_pkg::MAG_W-1:0] c4;
  logic [rsc_pkg::HALF_W-1:0]       hhi, hlo, ahi, alo, chi, clo;
  logic [rsc_pkg::D_W-1:0]          dval;
  logic                             d_ok, first, second;

  assign cur[0] = in_data.cur_x;
  assign cur[1] = in_data.cur_y;
  assign cur[2] = in_data.cur_z;
  assign prv[0] = in_data.prev_x;
  assign prv[1] = in_data.prev_y;
  assign prv[2] = in_data.prev_z;
  assign obs[0] = in_data.obstacle_x;
  assign obs[1] = in_data.obstacle_y;
  assign obs[2] = in_data.obstacle_z;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  // Stages 1 and 2: motion, offset from centre, radius sum, then products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dx1_r[k]  <= rsc_pkg::DIFF_W'(cur[k]) - rsc_pkg::DIFF_W'(prv[k]);
        e1_r[k]   <= rsc_pkg::DIFF_W'(prv[k]) - rsc_pkg::DIFF_W'(obs[k]);
        prv1_r[k] <= prv[k];
      end
      rsum1_r <= rsc_pkg::COORD_W'(in_data.mover_radius)
               + rsc_pkg::COORD_W'(in_data.obstacle_radius);
      for (int k = 0; k < 3; k++) begin
        dd2_r[k] <= rsc_pkg::PROD_W'(dx1_r[k]) * rsc_pkg::PROD_W'(dx1_r[k]);
        de2_r[k] <= rsc_pkg::PROD_W'(dx1_r[k]) * rsc_pkg::PROD_W'(e1_r[k]);
        ee2_r[k] <= rsc_pkg::PROD_W'(e1_r[k]) * rsc_pkg::PROD_W'(e1_r[k]);
        g2_r.ud[k]   <= dx1_r[k][rsc_pkg::DIFF_W-1] ? rsc_pkg::DIFF_W'(-dx1_r[k])
                                                     : rsc_pkg::DIFF_W'(dx1_r[k]);
        g2_r.dneg[k] <= dx1_r[k][rsc_pkg::DIFF_W-1];
      end
      g2_r.prv <= prv1_r;
      rr2_r    <= rsc_pkg::RR_W'(rsum1_r) * rsc_pkg::RR_W'(rsum1_r);
    end
  end

  // Stage 3: sums for a, half of b and |e|^2
  always_ff @(posedge clk) begin
    if (en) begin
      a3_r  <= rsc_pkg::MAG_W'(dd2_r[0]) + rsc_pkg::MAG_W'(dd2_r[1])
             + rsc_pkg::MAG_W'(dd2_r[2]);
      h3_r  <= rsc_pkg::MAG_W'(de2_r[0]) + rsc_pkg::MAG_W'(de2_r[1])
             + rsc_pkg::MAG_W'(de2_r[2]);
      ep3_r <= rsc_pkg::MAG_W'(ee2_r[0]) + rsc_pkg::MAG_W'(ee2_r[1])
             + rsc_pkg::MAG_W'(ee2_r[2]);
      rr3_r <= rr2_r;
      g3_r  <= g2_r;
    end
  end

  // Stage 4: c and magnitudes with signs
  assign c4 = ep3_r - $signed(rsc_pkg::MAG_W'(rr3_r));

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r     <= a3_r;
      azero4_r <= (a3_r == '0);
      hneg4_r  <= h3_r[rsc_pkg::MAG_W-1];
      habs4_r  <= h3_r[rsc_pkg::MAG_W-1] ? rsc_pkg::MAG_W'(-h3_r) : rsc_pkg::MAG_W'(h3_r);
      cneg4_r  <= c4[rsc_pkg::MAG_W-1];
      cpos4_r  <= !c4[rsc_pkg::MAG_W-1] && (c4 != '0);
      cabs4_r  <= c4[rsc_pkg::MAG_W-1] ? rsc_pkg::MAG_W'(-c4) : rsc_pkg::MAG_W'(c4);
      g4_r     <= g3_r;
    end
  end

  // Stage 5: half-width partial products of h^2 and a*c
  assign {hhi, hlo} = habs4_r;
  assign {ahi, alo} = a4_r;
  assign {chi, clo} = cabs4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh5_r    <= (2*rsc_pkg::HALF_W)'(hhi) * (2*rsc_pkg::HALF_W)'(hhi);
      hl5_r    <= (2*rsc_pkg::HALF_W)'(hhi) * (2*rsc_pkg::HALF_W)'(hlo);
      ll5_r    <= (2*rsc_pkg::HALF_W)'(hlo) * (2*rsc_pkg::HALF_W)'(hlo);
      p005_r   <= (2*rsc_pkg::HALF_W)'(alo) * (2*rsc_pkg::HALF_W)'(clo);
      p015_r   <= (2*rsc_pkg::HALF_W)'(alo) * (2*rsc_pkg::HALF_W)'(chi);
      p105_r   <= (2*rsc_pkg::HALF_W)'(ahi) * (2*rsc_pkg::HALF_W)'(clo);
      p115_r   <= (2*rsc_pkg::HALF_W)'(ahi) * (2*rsc_pkg::HALF_W)'(chi);
      a5_r     <= a4_r;
      habs5_r  <= habs4_r;
      hneg5_r  <= hneg4_r;
      cpos5_r  <= cpos4_r;
      cneg5_r  <= cneg4_r;
      azero5_r <= azero4_r;
      g5_r     <= g4_r;
    end
  end

  // Stage 6: assemble h^2 and a*c
  always_ff @(posedge clk) begin
    if (en) begin
      h26_r <= (rsc_pkg::SQR_W'(hh5_r) << (2*rsc_pkg::HALF_W))
             + (rsc_pkg::SQR_W'(hl5_r) << (rsc_pkg::HALF_W + 1))
             + rsc_pkg::SQR_W'(ll5_r);
      ac6_r <= (rsc_pkg::SQR_W'(p115_r) << (2*rsc_pkg::HALF_W))
             + (rsc_pkg::SQR_W'(p015_r) << rsc_pkg::HALF_W)
             + (rsc_pkg::SQR_W'(p105_r) << rsc_pkg::HALF_W)
             + rsc_pkg::SQR_W'(p005_r);
      a6_r     <= a5_r;
      habs6_r  <= habs5_r;
      hneg6_r  <= hneg5_r;
      cpos6_r  <= cpos5_r;
      cneg6_r  <= cneg5_r;
      azero6_r <= azero5_r;
      g6_r     <= g5_r;
    end
  end

  // Stage 7: discriminant and which root is the first positive one
  always_comb begin
    if (cpos6_r) begin
      dval = rsc_pkg::D_W'(h26_r) - rsc_pkg::D_W'(ac6_r);
      d_ok = h26_r > ac6_r;
    end else begin
      dval = rsc_pkg::D_W'(h26_r) + rsc_pkg::D_W'(ac6_r);
      d_ok = (dval != '0);
    end
    first  = hneg6_r && cpos6_r;
    second = !first && (hneg6_r || cneg6_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_r.hit   <= !azero6_r && d_ok && (first || second);
      fo_r.first <= first;
      fo_r.hneg  <= hneg6_r;
      fo_r.habs  <= habs6_r;
      fo_r.a     <= a6_r;
      fo_r.d     <= dval;
      fo_r.g     <= g6_r;
    end
  end

  assign fo_valid = vld_r[6];
  assign fo       = fo_r;

endmodule

// ===== hdl/rsc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module rsc_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            fi_valid,
  input  rsc_pkg::front_t fi,
  output logic            so_valid,
  output rsc_pkg::root_t  so
);

  rsc_pkg::front_t               side_r [rsc_pkg::ROOT_W];
  logic [rsc_pkg::SQ_REM_W-1:0]  rem_r  [rsc_pkg::ROOT_W];
  logic [rsc_pkg::ROOT_W-1:0]    root_r [rsc_pkg::ROOT_W];
  logic [rsc_pkg::ROOT_W-1:0]    vld_r;

  for (genvar j = 0; j < rsc_pkg::ROOT_W; j++) begin : g_stage
    localparam int Bit = rsc_pkg::ROOT_W - 1 - j;

    rsc_pkg::front_t              side_in;
    logic [rsc_pkg::SQ_REM_W-1:0] rem_in, cur, trial;
    logic [rsc_pkg::ROOT_W-1:0]   root_in;
    logic                         vld_in;

    if (j == 0) begin : g_head
      assign side_in = fi;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = fi_valid;
    end else begin : g_body
      assign side_in = side_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign vld_in  = vld_r[j-1];
    end

    // Bring down the next pair of radicand bits and try a one
    assign cur   = {rem_in[rsc_pkg::SQ_REM_W-3:0], side_in.d[2*Bit +: 2]};
    assign trial = rsc_pkg::SQ_REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j] <= side_in;
        if (cur >= trial) begin
          rem_r[j]  <= cur - trial;
          root_r[j] <= {root_in[rsc_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= cur;
          root_r[j] <= {root_in[rsc_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign so_valid = vld_r[rsc_pkg::ROOT_W-1];
  assign so.hit   = side_r[rsc_pkg::ROOT_W-1].hit;
  assign so.first = side_r[rsc_pkg::ROOT_W-1].first;
  assign so.hneg  = side_r[rsc_pkg::ROOT_W-1].hneg;
  assign so.habs  = side_r[rsc_pkg::ROOT_W-1].habs;
  assign so.a     = side_r[rsc_pkg::ROOT_W-1].a;
  assign so.root  = root_r[rsc_pkg::ROOT_W-1];
  assign so.g     = side_r[rsc_pkg::ROOT_W-1].g;

endmodule

// ===== hdl/rsc_div.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage
`timescale 1ns / 1ps
module rsc_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rsc_pkg::DIV_W-1:0] num,
  input  logic [rsc_pkg::MAG_W-1:0] den,
  output logic                      ovf,
  output logic [rsc_pkg::Q_W-1:0]   q,
  output logic                      rem_nz
);

  logic [rsc_pkg::DIV_W-1:0] rem_r [rsc_pkg::Q_W+1];
  logic [rsc_pkg::MAG_W-1:0] den_r [rsc_pkg::Q_W];
  logic [rsc_pkg::Q_W-1:0]   q_r   [rsc_pkg::Q_W+1];
  logic                      ovf_r [rsc_pkg::Q_W+1];

  // Entry: quotient too large to hold in the kept bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= num >= (rsc_pkg::DIV_W'(den) << rsc_pkg::Q_W);
    end
  end

  for (genvar k = 1; k <= rsc_pkg::Q_W; k++) begin : g_step
    localparam int Bit = rsc_pkg::Q_W - k;

    logic [rsc_pkg::DIV_W-1:0] sh;
    logic                      ge;
    logic [rsc_pkg::Q_W-1:0]   q_nxt;

    always_comb begin
      sh       = rsc_pkg::DIV_W'(den_r[k-1]) << Bit;
      ge       = rem_r[k-1] >= sh;
      q_nxt    = q_r[k-1];
      q_nxt[Bit] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? rem_r[k-1] - sh : rem_r[k-1];
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_r[k-1];
      end
    end

    if (k < rsc_pkg::Q_W) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign ovf    = ovf_r[rsc_pkg::Q_W];
  assign q      = q_r[rsc_pkg::Q_W];
  assign rem_nz = (rem_r[rsc_pkg::Q_W] != '0);

endmodule

// ===== hdl/ray_sphere_collision_point.sv =====
// Top level of the swept-sphere collision pipeline
//
//   channel | ports                        | payload
//   --------+------------------------------+----------------------
//   input   | in_valid, in_ready, in_data  | rsc_pkg::in_t
//   result  | out_valid, out_ready, out_data | rsc_pkg::out_t
//
// One item enters per cycle while the pipeline advances; each result passes through
// 7 front-end stages, 69 square-root stages (one root bit each), 3 numerator stages,
// 35 divider stages (overflow check, then one quotient bit each) and the output register.
// The whole pipeline advances together while the output register is empty or taken.
// Reset (rst_n low at a clock edge) clears every valid bit; data registers hold no reset.
`timescale 1ns / 1ps
module ray_sphere_collision_point (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rsc_pkg::out_t  out_data
);

  localparam int DLY = rsc_pkg::Q_W + 1;

  logic            en;
  logic            fo_valid, so_valid;
  rsc_pkg::front_t fo;
  rsc_pkg::root_t  so;

  // Root numerator stage
  logic                                nvld_r;
  logic                                nhit_r;
  logic [rsc_pkg::N_W-1:0]             n_r;
  logic [rsc_pkg::MAG_W-1:0]           na_r;
  rsc_pkg::geom_t                      ng_r;
  // Partial products stage
  logic                                pvld_r;
  logic                                phit_r;
  logic [rsc_pkg::PP_W-1:0]            pp_r [3][rsc_pkg::NCH];
  logic [rsc_pkg::N_W-1:0]             pn_r;
  logic [rsc_pkg::MAG_W-1:0]           pa_r;
  rsc_pkg::geom_t                      pg_r;
  // Numerator sum stage
  logic                                svld_r;
  rsc_pkg::post_t                      spost_r;
  logic [rsc_pkg::DIV_W-1:0]           num_r [3];
  logic [rsc_pkg::DIV_W-1:0]           numt_r;
  logic [rsc_pkg::MAG_W-1:0]           sa_r;
  // Side line beside the dividers
  logic [DLY-1:0]                      dvld_r;
  rsc_pkg::post_t                      dpost_r [DLY];
  // Output register
  logic                                out_valid_r;
  rsc_pkg::out_t                       out_r, out_nxt;

  logic [rsc_pkg::NCH*rsc_pkg::NCH_W-1:0] n_ext;
  logic [rsc_pkg::N_W-1:0]             n_nxt;
  logic                                ovf_k [3];
  logic [rsc_pkg::Q_W-1:0]             q_k   [3];
  logic                                rnz_k [3];
  logic                                ovf_t, rnz_t;
  logic [rsc_pkg::Q_W-1:0]             q_t;
  logic [rsc_pkg::Q_W:0]               qc;
  logic signed [rsc_pkg::V_W-1:0]      pv, qv, v;
  rsc_pkg::coord_t                     pt [3];

  // Global advance: the output register is empty or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .fo_valid (fo_valid),
    .fo       (fo)
  );

  rsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .fi_valid (fo_valid),
    .fi       (fo),
    .so_valid (so_valid),
    .so       (so)
  );

  // Root numerator: -h - s, -h + s or s - h with the sign already folded in
  always_comb begin
    if (so.first) begin
      n_nxt = rsc_pkg::N_W'(so.habs) - rsc_pkg::N_W'(so.root);
    end else if (so.hneg) begin
      n_nxt = rsc_pkg::N_W'(so.habs) + rsc_pkg::N_W'(so.root);
    end else begin
      n_nxt = rsc_pkg::N_W'(so.root) - rsc_pkg::N_W'(so.habs);
    end
  end

  assign n_ext = (rsc_pkg::NCH*rsc_pkg::NCH_W)'(n_r);

  // Valid bits of the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvld_r      <= 1'b0;
      pvld_r      <= 1'b0;
      svld_r      <= 1'b0;
      dvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      nvld_r      <= so_valid;
      pvld_r      <= nvld_r;
      svld_r      <= pvld_r;
      dvld_r      <= {dvld_r[DLY-2:0], svld_r};
      out_valid_r <= dvld_r[DLY-1];
    end
  end

  // Numerator, partial products of N * |d_k|, and their sums
  always_ff @(posedge clk) begin
    if (en) begin
      nhit_r <= so.hit;
      n_r    <= n_nxt;
      na_r   <= so.a;
      ng_r   <= so.g;

      phit_r <= nhit_r;
      pn_r   <= n_r;
      pa_r   <= na_r;
      pg_r   <= ng_r;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < rsc_pkg::NCH; c++) begin
          pp_r[k][c] <= rsc_pkg::PP_W'(n_ext[c*rsc_pkg::NCH_W +: rsc_pkg::NCH_W])
                      * rsc_pkg::PP_W'(ng_r.ud[k]);
        end
      end

      for (int k = 0; k < 3; k++) begin
        num_r[k] <= (rsc_pkg::DIV_W'(pp_r[k][0]))
                  + (rsc_pkg::DIV_W'(pp_r[k][1]) << rsc_pkg::NCH_W)
                  + (rsc_pkg::DIV_W'(pp_r[k][2]) << (2*rsc_pkg::NCH_W));
      end
      numt_r       <= rsc_pkg::DIV_W'(pn_r) << rsc_pkg::FRAC_W;
      sa_r         <= pa_r;
      spost_r.hit  <= phit_r;
      spost_r.prv  <= pg_r.prv;
      spost_r.dneg <= pg_r.dneg;
    end
  end

  // Side line that matches the divider latency
  always_ff @(posedge clk) begin
    if (en) begin
      dpost_r[0] <= spost_r;
      for (int i = 1; i < DLY; i++) begin
        dpost_r[i] <= dpost_r[i-1];
      end
    end
  end

  rsc_div u_div_t (
    .clk    (clk),
    .en     (en),
    .num    (numt_r),
    .den    (sa_r),
    .ovf    (ovf_t),
    .q      (q_t),
    .rem_nz (rnz_t)
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    rsc_div u_div (
      .clk    (clk),
      .en     (en),
      .num    (num_r[k]),
      .den    (sa_r),
      .ovf    (ovf_k[k]),
      .q      (q_k[k]),
      .rem_nz (rnz_k[k])
    );
  end

  // Result: point from the previous position, quotient rounded toward minus infinity
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc = {1'b0, q_k[k]} + (rsc_pkg::Q_W+1)'(dpost_r[DLY-1].dneg[k] && rnz_k[k]);
      pv = rsc_pkg::V_W'($signed(dpost_r[DLY-1].prv[k]));
      qv = $signed(rsc_pkg::V_W'(qc));
      v  = dpost_r[DLY-1].dneg[k] ? pv - qv : pv + qv;
      if (ovf_k[k]) begin
        pt[k] = dpost_r[DLY-1].dneg[k] ? {1'b1, {(rsc_pkg::COORD_W-1){1'b0}}}
                                        : {1'b0, {(rsc_pkg::COORD_W-1){1'b1}}};
      end else if ((v[rsc_pkg::V_W-1:rsc_pkg::COORD_W-1] != '0)
                   && (v[rsc_pkg::V_W-1:rsc_pkg::COORD_W-1] != '1)) begin
        pt[k] = v[rsc_pkg::V_W-1] ? {1'b1, {(rsc_pkg::COORD_W-1){1'b0}}}
                                  : {1'b0, {(rsc_pkg::COORD_W-1){1'b1}}};
      end else begin
        pt[k] = v[rsc_pkg::COORD_W-1:0];
      end
    end
    out_nxt = '0;
    if (dpost_r[DLY-1].hit) begin
      out_nxt.hit   = 1'b1;
      out_nxt.hit_x = pt[0];
      out_nxt.hit_y = pt[1];
      out_nxt.hit_z = pt[2];
      out_nxt.hit_time = (ovf_t || (q_t[rsc_pkg::Q_W-1:rsc_pkg::COORD_W] != '0))
                       ? '1 : q_t[rsc_pkg::COORD_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  `include "ray_sphere_collision_point_assert.svh"

  `RSC_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit, out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.hit_z == '0 && out_data.hit_time == '0, "missed item carries nonzero fields")
  `RSC_ASSERT_IMP(a_hit_moves, nvld_r && nhit_r, na_r != '0, "hit flagged with zero motion")
  `RSC_ASSERT_NXT(a_rst_empty, !rst_n, !out_valid && !nvld_r, "valid bits survive reset")

endmodule

// ===== test/tb_top.sv =====
// Testbench for the swept-sphere collision pipeline: directed table, then random queries
`timescale 1ns / 1ps
module tb_top;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  localparam int N_RANDOM = 1800;
  localparam int PIPE_LATENCY = 115;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int IN_BITS = $bits(rsc_pkg::in_t);
  localparam longint ONE = 64'sd65536;
  localparam longint P10 = 10 * ONE;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam longint RMAX = 64'sd2147483647;

  typedef struct {
    rsc_pkg::in_t  query;
    bit            known;
    rsc_pkg::out_t answer;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rsc_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsc_pkg::out_t out_data;

  rsc_pkg::out_t pending_hits[$];
  stim_row_t     stim_table[$];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            calm = 1'b0;

  ray_sphere_collision_point dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Exact collision solution in wide integers
  function automatic rsc_pkg::out_t solve_collision(rsc_pkg::in_t q);
    logic [255:0] a, hp, hn, ep, rr, habs, cabs, h2, ac, disc, root, cand, num, quo, rem, t;
    longint cur[3], prv[3], obs[3], dk[3], e;
    logic [63:0] ud[3], ue;
    longint v;
    bit hneg, cpos, cneg, first;
    rsc_pkg::out_t r;
    r = '0;
    a = '0; hp = '0; hn = '0; ep = '0;
    cur[0] = longint'(q.cur_x); cur[1] = longint'(q.cur_y); cur[2] = longint'(q.cur_z);
    prv[0] = longint'(q.prev_x); prv[1] = longint'(q.prev_y); prv[2] = longint'(q.prev_z);
    obs[0] = longint'(q.obstacle_x); obs[1] = longint'(q.obstacle_y);
    obs[2] = longint'(q.obstacle_z);
    for (int k = 0; k < 3; k++) begin
      dk[k] = cur[k] - prv[k];
      e = prv[k] - obs[k];
      ud[k] = dk[k] < 0 ? 64'(-dk[k]) : 64'(dk[k]);
      ue = e < 0 ? 64'(-e) : 64'(e);
      a = a + 256'(ud[k]) * 256'(ud[k]);
      ep = ep + 256'(ue) * 256'(ue);
      t = 256'(ud[k]) * 256'(ue);
      if ((dk[k] < 0) != (e < 0)) hn = hn + t;
      else hp = hp + t;
    end
    rr = 256'({33'd0, q.mover_radius} + {33'd0, q.obstacle_radius});
    rr = rr * rr;
    if (a == 0) return r;
    hneg = hn > hp;
    habs = hneg ? hn - hp : hp - hn;
    cpos = ep > rr;
    cneg = ep < rr;
    cabs = cneg ? rr - ep : ep - rr;
    h2 = habs * habs;
    ac = a * cabs;
    if (cpos) begin
      if (h2 <= ac) return r;
      disc = h2 - ac;
    end else begin
      disc = h2 + ac;
      if (disc == 0) return r;
    end
    if (hneg && cpos) first = 1'b1;
    else if (hneg || cneg) first = 1'b0;
    else return r;
    // bitwise integer square root
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (256'd1 << i);
      if (cand * cand <= disc) root = cand;
    end
    if (first) num = habs - root;
    else if (hneg) num = habs + root;
    else num = root - habs;
    r.hit = 1'b1;
    quo = (num << rsc_pkg::FRAC_W) / a;
    r.hit_time = quo > 256'hFFFF_FFFF ? '1 : quo[31:0];
    for (int k = 0; k < 3; k++) begin
      t = num * 256'(ud[k]);
      quo = t / a;
      rem = t % a;
      if (dk[k] < 0 && rem != 0) quo = quo + 1;
      if (quo >= (256'd1 << 62)) v = dk[k] < 0 ? SMIN : SMAX;
      else begin
        v = dk[k] < 0 ? prv[k] - longint'(quo[63:0]) : prv[k] + longint'(quo[63:0]);
        if (v > SMAX) v = SMAX;
        if (v < SMIN) v = SMIN;
      end
      case (k)
        0: r.hit_x = v[31:0];
        1: r.hit_y = v[31:0];
        default: r.hit_z = v[31:0];
      endcase
    end
    return r;
  endfunction

  function automatic rsc_pkg::in_t make_query(longint cx, longint cy, longint cz,
                                              longint px, longint py, longint pz,
                                              longint mr, longint ox, longint oy,
                                              longint oz, longint orad);
    rsc_pkg::in_t q;
    q.cur_x = cx[31:0]; q.cur_y = cy[31:0]; q.cur_z = cz[31:0];
    q.prev_x = px[31:0]; q.prev_y = py[31:0]; q.prev_z = pz[31:0];
    q.mover_radius = mr[30:0];
    q.obstacle_x = ox[31:0]; q.obstacle_y = oy[31:0]; q.obstacle_z = oz[31:0];
    q.obstacle_radius = orad[30:0];
    return q;
  endfunction

  function automatic void add_row(rsc_pkg::in_t q, bit known);
    stim_row_t row;
    row.query = q;
    row.known = known;
    row.answer = '0;
    stim_table.push_back(row);
  endfunction

  // Random query: mostly paths that pass near the obstacle, some raw noise
  function automatic rsc_pkg::in_t random_query();
    rsc_pkg::in_t q;
    longint p[3], d[3], o[3];
    longint span, rad;
    int mode;
    mode = $urandom_range(99);
    if (mode < 20) begin
      q = IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom});
      return q;
    end
    span = (mode < 30) ? 64'sd255 : longint'(1) << $urandom_range(28, 8);
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'($urandom_range(2 * 30'h3FFF_FFFF)) - 64'sd1073741823;
      d[k] = longint'($urandom_range(2 * span)) - span;
      if ($urandom_range(9) == 0) d[k] = 0;
      // obstacle somewhere along the path, up to twice its length, jittered
      o[k] = p[k] + (d[k] * longint'($urandom_range(512)) >>> 8)
             + longint'($urandom_range(span / 4)) - span / 8;
    end
    rad = span / 2;
    q = make_query(p[0] + d[0], p[1] + d[1], p[2] + d[2], p[0], p[1], p[2],
                   longint'($urandom_range(rad)), o[0], o[1], o[2],
                   longint'($urandom_range(rad)));
    return q;
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h got %h", name, want, got);
    end
  endfunction

  // Result checker and watchdog
  always @(posedge clk) begin
    rsc_pkg::out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ray_sphere_collision_point verification failed");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) $display("unexpected result %h", out_data);
        end else begin
          want = pending_hits.pop_front();
          report_field("hit", 32'(want.hit), 32'(out_data.hit));
          report_field("hit_x", want.hit_x, out_data.hit_x);
          report_field("hit_y", want.hit_y, out_data.hit_y);
          report_field("hit_z", want.hit_z, out_data.hit_z);
          report_field("hit_time", want.hit_time, out_data.hit_time);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (rst_n) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 15);
  end

  // Present one item and hold it until taken
  task automatic send_item(rsc_pkg::in_t q, rsc_pkg::out_t want);
    bit taken;
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end
    pending_hits.push_back(want);
  endtask

  initial begin
    rsc_pkg::in_t q;
    int drain;
    // zero motion and the misses below give all-zero results
    add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(make_query(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, RMAX, SMIN, SMIN, SMIN, RMAX),
            1'b1);
    add_row(make_query(P10, 0, 0, -P10, 0, 0, ONE, 0, 0, 0, ONE), 1'b0);
    add_row(make_query(P10, 100 * ONE, 0, -P10, 100 * ONE, 0, ONE, 0, 0, 0, ONE), 1'b1);
    // start inside the combined sphere
    add_row(make_query(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5 * ONE), 1'b0);
    // grazing path, discriminant zero
    add_row(make_query(P10, 2 * ONE, 0, -P10, 2 * ONE, 0, ONE, 0, 0, 0, ONE), 1'b1);
    // moving away from the obstacle
    add_row(make_query(P10, 0, 0, 5 * ONE, 0, 0, ONE, 0, 0, 0, 0), 1'b1);
    // coordinate extremes, saturating outputs
    add_row(make_query(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, RMAX, 0, 0, 0, RMAX), 1'b0);
    add_row(make_query(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 0, SMAX, SMAX, SMAX, 0), 1'b0);
    add_row(make_query(SMIN, 0, SMAX, SMAX, 0, SMIN, RMAX, SMIN, 0, SMAX, RMAX), 1'b0);
    // collision time below one LSB
    add_row(make_query(SMAX, 0, 0, 0, 0, 0, 1, 3, 0, 0, 0), 1'b0);
    // touching at the start and heading in
    add_row(make_query(0, 0, 0, -2 * ONE, 0, 0, ONE, 0, 0, 0, ONE), 1'b0);
    // hit far beyond one step, and a time that saturates
    add_row(make_query(ONE, 0, 0, 0, 0, 0, ONE, 1000 * ONE, 0, 0, ONE), 1'b0);
    add_row(make_query(1, 0, 0, 0, 0, 0, 0, SMAX, 0, 0, 0), 1'b0);
    add_row(make_query(0, -1, 0, 0, 0, 0, 0, 0, SMIN, 0, 0), 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (stim_table[i])
      send_item(stim_table[i].query,
                stim_table[i].known ? stim_table[i].answer : solve_collision(stim_table[i].query));
    in_valid <= 1'b0;
    // hold off until the pipeline has drained
    while (pending_hits.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 600 && n < 900);
      q = random_query();
      send_item(q, solve_collision(q));
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_hits.size() != 0) @(negedge clk);
    drain = 0;
    while (drain < PIPE_LATENCY + 20) begin
      @(negedge clk);
      drain++;
    end
    if (mismatches == 0 && pending_hits.size() == 0)
      $display("ray_sphere_collision_point verification clean");
    else
      $display("ray_sphere_collision_point verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rsc_pkg.sv
hdl/rsc_front.sv
hdl/rsc_sqrt.sv
hdl/rsc_div.sv
hdl/ray_sphere_collision_point.sv
test/tb_top.sv
